FILE: rtl/gwc_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes and defaults for the Gaussian window convolution block.
package gwc_pkg;

   // Payload widths
   localparam int PIX_W      = 8;
   localparam int COEF_W     = 16;
   localparam int CIDX_W     = 5;
   localparam int OP_W       = 1;
   localparam int POS_W      = 10;

   // Configuration register widths and port shape
   localparam int WIDTH_REG_W = 11;
   localparam int KSIZE_W     = 3;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 11;

   // Effective-size domains, wide enough for the largest parameter values
   localparam int KER_W  = 4;
   localparam int WEFF_W = 13;

   // Opcodes
   localparam logic [OP_W-1:0] OP_PIXEL = 1'b0;
   localparam logic [OP_W-1:0] OP_COEF  = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_SIZE = 1'b1;

   // Register reset values
   localparam logic [WIDTH_REG_W-1:0] IMAGE_WIDTH_RST = 11'd640;
   localparam logic [KSIZE_W-1:0]     KERNEL_SIZE_RST = 3'd3;

   // Q0.16 rounding
   localparam int FRAC_W     = 16;
   localparam int ROUND_HALF = 32768;
   localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

   // Build defaults
   localparam int MAX_KERNEL_DEF = 5;
   localparam int MAX_WIDTH_DEF  = 1024;

endpackage

FILE: rtl/gwc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module gwc_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/gaussian_window_convolution.sv
`timescale 1ns / 1ps
// Top level of the streaming Gaussian window convolution.
// A result word passes stage 1 (line-store read), stage 2 (window update and
// multiply), stage 3 (row sums) and the output register (final sum/round).
// Throughput: one word per cycle, pixel or coefficient, unless rsp_stall
// holds the pipeline; bound by one line-store read-modify-write per pixel.
// Reset: config returns to width 640 / kernel 3, counters, window and kernel
// clear at once; the line store is not cleared and holds garbage until written.
module gaussian_window_convolution #(
   parameter int MAX_KERNEL = gwc_pkg::MAX_KERNEL_DEF,
   parameter int MAX_WIDTH  = gwc_pkg::MAX_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [gwc_pkg::OP_W-1:0]        req_opcode,
   input  logic                            req_frame_start,
   input  logic [gwc_pkg::PIX_W-1:0]       req_pixel_value,
   input  logic [gwc_pkg::CIDX_W-1:0]      req_coef_index,
   input  logic [gwc_pkg::COEF_W-1:0]      req_coef_value,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [gwc_pkg::PIX_W-1:0]       rsp_smoothed_pixel,
   output logic [gwc_pkg::POS_W-1:0]       rsp_out_row,
   output logic [gwc_pkg::POS_W-1:0]       rsp_out_col,
   // configuration write port
   input  logic                            csr_write_en,
   input  logic [gwc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gwc_pkg::CSR_DATA_W-1:0]  csr_data
);
   import gwc_pkg::*;

   // Line store keeps MAX_KERNEL-1 rows; one RAM word is one column of them.
   localparam int LS_ROWS = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
   localparam int LS_W    = LS_ROWS * PIX_W;
   localparam int ADDR_W  = $clog2(MAX_WIDTH);
   localparam int NTAPS   = MAX_KERNEL * MAX_KERNEL;
   localparam int TIDX_W  = 8;
   localparam int PROD_W  = PIX_W + COEF_W;
   localparam int LOG_K   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int RSUM_W  = PROD_W + LOG_K;
   localparam int TSUM_W  = PROD_W + 2 * LOG_K + 1;

   // ---------------------------------------------------------------
   // Configuration registers and their effective values
   // ---------------------------------------------------------------
   logic [WIDTH_REG_W-1:0] width_ff;
   logic [KSIZE_W-1:0]     ksize_ff;
   logic [WEFF_W-1:0]      width_eff;
   logic [KER_W-1:0]       k_eff;
   logic [KER_W-1:0]       base;
   logic [KER_W-1:0]       half;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= IMAGE_WIDTH_RST;
         ksize_ff <= KERNEL_SIZE_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: width_ff <= csr_data[WIDTH_REG_W-1:0];
            CSR_KERNEL_SIZE: ksize_ff <= csr_data[KSIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // Width 0 acts as 1, above the build limit clamps to it.
   // Kernel 0 acts as 1, clamp to the build limit, even sizes drop to odd.
   always_comb begin
      width_eff = WEFF_W'(width_ff);
      if (width_eff == '0) begin
         width_eff = WEFF_W'(1);
      end
      if (width_eff > WEFF_W'(MAX_WIDTH)) begin
         width_eff = WEFF_W'(MAX_WIDTH);
      end
      k_eff = KER_W'(ksize_ff);
      if (k_eff == '0) begin
         k_eff = KER_W'(1);
      end
      if (k_eff > KER_W'(MAX_KERNEL)) begin
         k_eff = KER_W'(MAX_KERNEL);
      end
      if (!k_eff[0]) begin
         k_eff = k_eff - KER_W'(1);
      end
   end

   assign base = KER_W'(MAX_KERNEL) - k_eff;
   assign half = k_eff >> 1;

   // ---------------------------------------------------------------
   // Pipeline handshake: each stage moves when the next one is free
   // ---------------------------------------------------------------
   logic s1_v_ff, s2_v_ff, s3_v_ff, out_v_ff;
   logic out_free, s3_free, s2_free, s1_free;
   logic s1_go, s2_go, s3_go, req_go;

   assign out_free  = !out_v_ff || !rsp_stall;
   assign s3_go     = s3_v_ff && out_free;
   assign s3_free   = !s3_v_ff || out_free;
   assign s2_go     = s2_v_ff && s3_free;
   assign s2_free   = !s2_v_ff || s3_free;
   assign s1_go     = s1_v_ff && s2_free;
   assign s1_free   = !s1_v_ff || s2_free;
   assign req_stall = !s1_free;
   assign req_go    = req_valid && s1_free;

   // ---------------------------------------------------------------
   // Accept: position counters and line-store read issue
   // ---------------------------------------------------------------
   logic [POS_W-1:0] col_ff, row_ff;
   logic [POS_W-1:0] col_start, row_start, col_cur;
   logic [POS_W:0]   col_inc;
   logic             col_wrap, emit_cur, req_is_pix;

   assign req_is_pix = (req_opcode == OP_PIXEL);

   always_comb begin
      // frame start clears the counters ahead of this pixel
      col_start = req_frame_start ? '0 : col_ff;
      row_start = req_frame_start ? '0 : row_ff;
      col_cur   = (WEFF_W'(col_start) >= width_eff) ? '0 : col_start;
      emit_cur  = (row_start >= POS_W'(k_eff - KER_W'(1))) &&
                  (col_cur   >= POS_W'(k_eff - KER_W'(1)));
      col_inc   = (POS_W + 1)'(col_cur) + (POS_W + 1)'(1);
      col_wrap  = (WEFF_W'(col_inc) >= width_eff) || col_inc[POS_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_go && req_is_pix) begin
         col_ff <= col_wrap ? '0 : col_inc[POS_W-1:0];
         row_ff <= col_wrap ? row_start + POS_W'(1) : row_start;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: line-store word arrives; window and kernel update on leave
   // ---------------------------------------------------------------
   logic [OP_W-1:0]   s1_op_ff;
   logic [PIX_W-1:0]  s1_pix_ff;
   logic [POS_W-1:0]  s1_col_ff, s1_row_ff;
   logic              s1_emit_ff;
   logic [CIDX_W-1:0] s1_cidx_ff;
   logic [COEF_W-1:0] s1_cval_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (req_go) begin
         s1_v_ff <= 1'b1;
      end else if (s1_go) begin
         s1_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_go) begin
         s1_op_ff   <= req_opcode;
         s1_pix_ff  <= req_pixel_value;
         s1_col_ff  <= col_cur;
         s1_row_ff  <= row_start;
         s1_emit_ff <= emit_cur;
         s1_cidx_ff <= req_coef_index;
         s1_cval_ff <= req_coef_value;
      end
   end

   logic s1_is_pix, s1_pix_go, s1_coef_go;
   assign s1_is_pix  = (s1_op_ff == OP_PIXEL);
   assign s1_pix_go  = s1_go && s1_is_pix;
   assign s1_coef_go = s1_go && !s1_is_pix;

   // RAM and the forwarding of the last write: a read issued on the same
   // edge as a write to the same column returns the old word.
   logic [LS_W-1:0]   ram_rdata, old_word, new_word;
   logic [ADDR_W-1:0] fwd_addr_ff;
   logic [LS_W-1:0]   fwd_data_ff;
   logic              fwd_v_ff;

   gwc_ram #(
      .WIDTH (LS_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_pix_go),
      .wr_addr (ADDR_W'(s1_col_ff)),
      .wr_data (new_word),
      .rd_en   (req_go && req_is_pix),
      .rd_addr (ADDR_W'(col_cur)),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_v_ff <= 1'b0;
      end else if (s1_pix_go) begin
         fwd_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_pix_go) begin
         fwd_addr_ff <= ADDR_W'(s1_col_ff);
         fwd_data_ff <= new_word;
      end
   end

   assign old_word = (fwd_v_ff && fwd_addr_ff == ADDR_W'(s1_col_ff)) ? fwd_data_ff : ram_rdata;

   // Push the new pixel in at the bottom row of the column, age the rest.
   always_comb begin
      new_word[PIX_W-1:0] = s1_pix_ff;
      for (int r = 1; r < LS_ROWS; r++) begin
         new_word[r*PIX_W +: PIX_W] = old_word[(r-1)*PIX_W +: PIX_W];
      end
   end

   // Window: shift left, newest column enters at the right,
   // newest row at the bottom.
   logic [PIX_W-1:0]  column [MAX_KERNEL];
   logic [PIX_W-1:0]  win_ff [MAX_KERNEL][MAX_KERNEL];
   logic [PIX_W-1:0]  win_in [MAX_KERNEL][MAX_KERNEL];
   logic [COEF_W-1:0] wgt_ff [NTAPS];

   always_comb begin
      column[0] = s1_pix_ff;
      for (int n = 1; n < MAX_KERNEL; n++) begin
         column[n] = old_word[(n-1)*PIX_W +: PIX_W];
      end
      for (int i = 0; i < MAX_KERNEL; i++) begin
         for (int j = 0; j + 1 < MAX_KERNEL; j++) begin
            win_in[i][j] = win_ff[i][j+1];
         end
         win_in[i][MAX_KERNEL-1] = column[MAX_KERNEL-1-i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_KERNEL; i++) begin
            for (int j = 0; j < MAX_KERNEL; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (s1_pix_go) begin
         win_ff <= win_in;
      end
   end

   // Coefficient loads take effect in stream order; out-of-range index drops.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int e = 0; e < NTAPS; e++) begin
            wgt_ff[e] <= '0;
         end
      end else if (s1_coef_go) begin
         for (int e = 0; e < NTAPS; e++) begin
            if (TIDX_W'(e) == TIDX_W'(s1_cidx_ff)) begin
               wgt_ff[e] <= s1_cval_ff;
            end
         end
      end
   end

   // Select the active K x K corner of the new window and multiply.
   logic [PIX_W-1:0]  row_pick [MAX_KERNEL][MAX_KERNEL];
   logic [PROD_W-1:0] prod_in  [MAX_KERNEL][MAX_KERNEL];

   always_comb begin
      logic [PIX_W-1:0] tap;
      for (int i = 0; i < MAX_KERNEL; i++) begin
         for (int b = 0; b < MAX_KERNEL; b++) begin
            row_pick[i][b] = '0;
         end
         for (int a = 0; a < MAX_KERNEL; a++) begin
            if (KER_W'(a) == base + KER_W'(i)) begin
               for (int b = 0; b < MAX_KERNEL; b++) begin
                  row_pick[i][b] = win_in[a][b];
               end
            end
         end
      end
      for (int i = 0; i < MAX_KERNEL; i++) begin
         for (int j = 0; j < MAX_KERNEL; j++) begin
            tap = '0;
            for (int b = 0; b < MAX_KERNEL; b++) begin
               if (KER_W'(b) == base + KER_W'(j)) begin
                  tap = row_pick[i][b];
               end
            end
            if (KER_W'(i) < k_eff && KER_W'(j) < k_eff) begin
               prod_in[i][j] = PROD_W'(tap) * PROD_W'(wgt_ff[i*MAX_KERNEL+j]);
            end else begin
               prod_in[i][j] = '0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: products of one window
   // ---------------------------------------------------------------
   logic [PROD_W-1:0] prod_ff [MAX_KERNEL][MAX_KERNEL];
   logic [POS_W-1:0]  s2_row_ff, s2_col_ff;
   logic              s2_load;

   // only interior centres continue past stage 1
   assign s2_load = s1_pix_go && s1_emit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_load) begin
         s2_v_ff <= 1'b1;
      end else if (s2_go) begin
         s2_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         prod_ff   <= prod_in;
         s2_row_ff <= s1_row_ff - POS_W'(half);
         s2_col_ff <= s1_col_ff - POS_W'(half);
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: row sums
   // ---------------------------------------------------------------
   logic [RSUM_W-1:0] rsum_ff [MAX_KERNEL];
   logic [RSUM_W-1:0] rsum_in [MAX_KERNEL];
   logic [POS_W-1:0]  s3_row_ff, s3_col_ff;

   always_comb begin
      for (int i = 0; i < MAX_KERNEL; i++) begin
         rsum_in[i] = '0;
         for (int j = 0; j < MAX_KERNEL; j++) begin
            rsum_in[i] = rsum_in[i] + RSUM_W'(prod_ff[i][j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (s2_go) begin
         s3_v_ff <= 1'b1;
      end else if (s3_go) begin
         s3_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_go) begin
         rsum_ff   <= rsum_in;
         s3_row_ff <= s2_row_ff;
         s3_col_ff <= s2_col_ff;
      end
   end

   // ---------------------------------------------------------------
   // Output register: total, round half up, saturate
   // ---------------------------------------------------------------
   logic [TSUM_W-1:0] total, rounded, scaled;
   logic [PIX_W-1:0]  pix_in;
   logic [PIX_W-1:0]  rsp_pix_ff;
   logic [POS_W-1:0]  rsp_row_ff, rsp_col_ff;

   always_comb begin
      total = '0;
      for (int i = 0; i < MAX_KERNEL; i++) begin
         total = total + TSUM_W'(rsum_ff[i]);
      end
      rounded = total + TSUM_W'(ROUND_HALF);
      scaled  = rounded >> FRAC_W;
      pix_in  = (scaled > TSUM_W'(PIX_MAX)) ? PIX_MAX : scaled[PIX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (s3_go) begin
         out_v_ff <= 1'b1;
      end else if (out_free) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_go) begin
         rsp_pix_ff <= pix_in;
         rsp_row_ff <= s3_row_ff;
         rsp_col_ff <= s3_col_ff;
      end
   end

   assign rsp_valid          = out_v_ff;
   assign rsp_smoothed_pixel = rsp_pix_ff;
   assign rsp_out_row        = rsp_row_ff;
   assign rsp_out_col        = rsp_col_ff;

endmodule
